[src/assert_macros.svh]
// Assertion macros shared by the triangle normal quantizer RTL.
// Assumes the including module has signals named clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ANY(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[src/tfnq_pkg.sv]
// Shared constants and types for the triangle face normal quantizer.
// No dependencies.
package tfnq_pkg;

   localparam int COORD_WIDTH_DEFAULT = 24;
   localparam int Q_BITS              = 7;   // output magnitude 0..127
   localparam int OUT_WIDTH           = 8;
   // 127*127 = 2^14 - 2^8 + 1
   localparam int SCALE_SQ_HI         = 14;
   localparam int SCALE_SQ_MID        = 8;

   typedef struct packed {
      logic valid;
      logic last;
      logic zero;
   } ctrl_type;

endpackage

[src/tfnq_req_if.sv]
// Request channel: one triangle per beat.
// Depends on tfnq_pkg for the default coordinate width.
interface tfnq_req_if #(parameter int COORD_WIDTH = tfnq_pkg::COORD_WIDTH_DEFAULT);
   logic                   valid;
   logic                   ready;
   logic [COORD_WIDTH-1:0] v0_x;
   logic [COORD_WIDTH-1:0] v0_y;
   logic [COORD_WIDTH-1:0] v0_z;
   logic [COORD_WIDTH-1:0] v1_x;
   logic [COORD_WIDTH-1:0] v1_y;
   logic [COORD_WIDTH-1:0] v1_z;
   logic [COORD_WIDTH-1:0] v2_x;
   logic [COORD_WIDTH-1:0] v2_y;
   logic [COORD_WIDTH-1:0] v2_z;
   logic                   is_last;

   modport source (output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
                   v2_x, v2_y, v2_z, is_last, input ready);
   modport sink   (input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
                   v2_x, v2_y, v2_z, is_last, output ready);
endinterface

[src/tfnq_rsp_if.sv]
// Response channel: one quantized face normal per beat.
// Depends on tfnq_pkg for the output width.
interface tfnq_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [tfnq_pkg::OUT_WIDTH-1:0]      normal_x;
   logic [tfnq_pkg::OUT_WIDTH-1:0]      normal_y;
   logic [tfnq_pkg::OUT_WIDTH-1:0]      normal_z;
   logic                                last_out;

   modport source (output valid, normal_x, normal_y, normal_z, last_out, input ready);
   modport sink   (input valid, normal_x, normal_y, normal_z, last_out, output ready);
endinterface

[src/tfnq_cross.sv]
// Edge vectors, cross product and component magnitudes: four pipeline stages.
// Depends on tfnq_pkg.
module tfnq_cross #(
   parameter int COORD_WIDTH = tfnq_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  tfnq_pkg::ctrl_type            ctrl_i,
   input  logic [2:0][COORD_WIDTH-1:0]   p0_i,
   input  logic [2:0][COORD_WIDTH-1:0]   p1_i,
   input  logic [2:0][COORD_WIDTH-1:0]   p2_i,
   output tfnq_pkg::ctrl_type            ctrl_o,
   output logic [2:0][2*COORD_WIDTH:0]   mag_o,
   output logic [2:0]                    neg_o
);
   localparam int E  = COORD_WIDTH + 1;
   localparam int PW = 2 * E;
   localparam int M  = PW - 1;

   tfnq_pkg::ctrl_type ctrl_a_ff, ctrl_b_ff, ctrl_c_ff, ctrl_d_ff;

   logic [2:0][E-1:0]  a_in, b_in, a_ff, b_ff;
   logic [5:0][PW-1:0] prod_in, prod_ff;
   logic [2:0][PW-1:0] n_in, n_ff, abs_t;
   logic [2:0][M-1:0]  mag_in, mag_ff;
   logic [2:0]         neg_in, neg_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         a_in[i] = {p1_i[i][COORD_WIDTH-1], p1_i[i]} - {p0_i[i][COORD_WIDTH-1], p0_i[i]};
         b_in[i] = {p2_i[i][COORD_WIDTH-1], p2_i[i]} - {p0_i[i][COORD_WIDTH-1], p0_i[i]};
      end
      // n = a x b, index 0 = x
      prod_in[0] = $signed(a_ff[1]) * $signed(b_ff[2]);
      prod_in[1] = $signed(a_ff[2]) * $signed(b_ff[1]);
      prod_in[2] = $signed(a_ff[2]) * $signed(b_ff[0]);
      prod_in[3] = $signed(a_ff[0]) * $signed(b_ff[2]);
      prod_in[4] = $signed(a_ff[0]) * $signed(b_ff[1]);
      prod_in[5] = $signed(a_ff[1]) * $signed(b_ff[0]);
      for (int i = 0; i < 3; i++) begin
         n_in[i]   = prod_ff[2*i] - prod_ff[2*i+1];
         neg_in[i] = n_ff[i][PW-1];
         abs_t[i]  = neg_in[i] ? (~n_ff[i] + 1'b1) : n_ff[i];
         mag_in[i] = abs_t[i][M-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_a_ff <= '0;
         ctrl_b_ff <= '0;
         ctrl_c_ff <= '0;
         ctrl_d_ff <= '0;
      end else if (adv) begin
         ctrl_a_ff <= ctrl_i;
         ctrl_b_ff <= ctrl_a_ff;
         ctrl_c_ff <= ctrl_b_ff;
         ctrl_d_ff <= ctrl_c_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff    <= a_in;
         b_ff    <= b_in;
         prod_ff <= prod_in;
         n_ff    <= n_in;
         mag_ff  <= mag_in;
         neg_ff  <= neg_in;
      end
   end

   assign ctrl_o = ctrl_d_ff;
   assign mag_o  = mag_ff;
   assign neg_o  = neg_ff;
endmodule

[src/tfnq_square.sv]
// Squared length and scaled squared components: three pipeline stages.
// Squares are built from half-width partial products. Depends on tfnq_pkg.
module tfnq_square #(
   parameter int COORD_WIDTH = tfnq_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                adv,
   input  tfnq_pkg::ctrl_type                  ctrl_i,
   input  logic [2:0][2*COORD_WIDTH:0]         mag_i,
   input  logic [2:0]                          neg_i,
   output tfnq_pkg::ctrl_type                  ctrl_o,
   output logic [2:0]                          neg_o,
   output logic [4*COORD_WIDTH+3:0]            len_o,
   output logic [2:0][4*COORD_WIDTH+15:0]      ksq_o
);
   localparam int M  = 2 * COORD_WIDTH + 1;
   localparam int H  = (M + 1) / 2;
   localparam int HI = M - H;
   localparam int SQ = 2 * M;
   localparam int LW = SQ + 2;
   localparam int KW = SQ + tfnq_pkg::SCALE_SQ_HI;

   tfnq_pkg::ctrl_type ctrl_e_ff, ctrl_f_ff, ctrl_g_ff;
   logic [2:0] neg_e_ff, neg_f_ff, neg_g_ff;

   logic [2:0][2*HI-1:0] hh_in, hh_ff;
   logic [2:0][HI+H-1:0] hl_in, hl_ff;
   logic [2:0][2*H-1:0]  ll_in, ll_ff;
   logic [2:0][SQ-1:0]   sq_in, sq_ff;
   logic [LW-1:0]        len_in, len_ff;
   logic [2:0][KW-1:0]   k_in, k_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         hh_in[i] = mag_i[i][M-1:H] * mag_i[i][M-1:H];
         hl_in[i] = mag_i[i][M-1:H] * mag_i[i][H-1:0];
         ll_in[i] = mag_i[i][H-1:0] * mag_i[i][H-1:0];
         sq_in[i] = (SQ'(hh_ff[i]) << (2*H)) + (SQ'(hl_ff[i]) << (H+1)) + SQ'(ll_ff[i]);
         k_in[i]  = (KW'(sq_ff[i]) << tfnq_pkg::SCALE_SQ_HI)
                  - (KW'(sq_ff[i]) << tfnq_pkg::SCALE_SQ_MID) + KW'(sq_ff[i]);
      end
      len_in = LW'(sq_ff[0]) + LW'(sq_ff[1]) + LW'(sq_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_e_ff <= '0;
         ctrl_f_ff <= '0;
         ctrl_g_ff <= '0;
      end else if (adv) begin
         ctrl_e_ff <= '{valid: ctrl_i.valid, last: ctrl_i.last, zero: ~|mag_i};
         ctrl_f_ff <= ctrl_e_ff;
         ctrl_g_ff <= ctrl_f_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         neg_e_ff <= neg_i;
         neg_f_ff <= neg_e_ff;
         neg_g_ff <= neg_f_ff;
         hh_ff    <= hh_in;
         hl_ff    <= hl_in;
         ll_ff    <= ll_in;
         sq_ff    <= sq_in;
         len_ff   <= len_in;
         k_ff     <= k_in;
      end
   end

   assign ctrl_o = ctrl_g_ff;
   assign neg_o  = neg_g_ff;
   assign len_o  = len_ff;
   assign ksq_o  = k_ff;
endmodule

[src/tfnq_qstep.sv]
// One step of the restoring search for q: tries bit BIT of q on all three lanes.
// Tracks q*q*len and q*len so a trial is shifts and adds. Depends on tfnq_pkg.
module tfnq_qstep #(
   parameter int COORD_WIDTH = tfnq_pkg::COORD_WIDTH_DEFAULT,
   parameter int BIT         = 0
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   adv,
   input  tfnq_pkg::ctrl_type                     ctrl_i,
   input  logic [2:0]                             neg_i,
   input  logic [4*COORD_WIDTH+3:0]               len_i,
   input  logic [2:0][4*COORD_WIDTH+15:0]         ksq_i,
   input  logic [2:0][4*COORD_WIDTH+15:0]         p_i,
   input  logic [2:0][4*COORD_WIDTH+10:0]         r_i,
   input  logic [2:0][tfnq_pkg::Q_BITS-1:0]       q_i,
   output tfnq_pkg::ctrl_type                     ctrl_o,
   output logic [2:0]                             neg_o,
   output logic [4*COORD_WIDTH+3:0]               len_o,
   output logic [2:0][4*COORD_WIDTH+15:0]         ksq_o,
   output logic [2:0][4*COORD_WIDTH+15:0]         p_o,
   output logic [2:0][4*COORD_WIDTH+10:0]         r_o,
   output logic [2:0][tfnq_pkg::Q_BITS-1:0]       q_o
);
   localparam int SQ = 4 * COORD_WIDTH + 2;
   localparam int LW = SQ + 2;
   localparam int KW = SQ + tfnq_pkg::SCALE_SQ_HI;
   localparam int RW = LW + tfnq_pkg::Q_BITS;
   localparam int TW = SQ + 16;

   tfnq_pkg::ctrl_type ctrl_ff;
   logic [2:0]                        neg_ff;
   logic [LW-1:0]                     len_ff;
   logic [2:0][KW-1:0]                k_ff, p_in, p_ff;
   logic [2:0][RW-1:0]                r_in, r_ff;
   logic [2:0][tfnq_pkg::Q_BITS-1:0]  q_in, q_ff;
   logic [2:0][TW-1:0]                trial;
   logic [2:0]                        take;

   // (q+b)^2 L = q^2 L + 2 b q L + b^2 L, with b = 2^BIT
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         trial[i] = TW'(p_i[i]) + (TW'(r_i[i]) << (BIT + 1)) + (TW'(len_i) << (2 * BIT));
         take[i]  = trial[i] <= TW'(ksq_i[i]);
         p_in[i]  = take[i] ? trial[i][KW-1:0] : p_i[i];
         r_in[i]  = take[i] ? (r_i[i] + (RW'(len_i) << BIT)) : r_i[i];
         q_in[i]  = q_i[i];
         q_in[i][BIT] = take[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (adv) begin
         ctrl_ff <= ctrl_i;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         neg_ff <= neg_i;
         len_ff <= len_i;
         k_ff   <= ksq_i;
         p_ff   <= p_in;
         r_ff   <= r_in;
         q_ff   <= q_in;
      end
   end

   assign ctrl_o = ctrl_ff;
   assign neg_o  = neg_ff;
   assign len_o  = len_ff;
   assign ksq_o  = k_ff;
   assign p_o    = p_ff;
   assign r_o    = r_ff;
   assign q_o    = q_ff;
endmodule

[src/triangle_face_normal_quantizer_top.sv]
// Triangle face normal quantizer, top level.
// Depends on tfnq_pkg, tfnq_req_if, tfnq_rsp_if, tfnq_cross, tfnq_square,
// tfnq_qstep and assert_macros.svh.
//
// Usage:
//   req carries one triangle per beat: three vertices in signed fixed point
//   (COORD_WIDTH bits per coordinate) and a last-triangle flag.
//   rsp returns one beat per triangle: each component of the unit face
//   normal (p1-p0) x (p2-p0) times 127, truncated toward zero, as a signed
//   byte, plus the copied flag. A zero-length normal gives all zeros.
//   A req beat reaches rsp valid through the edge and cross-product stages,
//   the square stages, 7 search steps (one bit of q each) and the output
//   register. Throughput is one triangle per cycle; the limit is the
//   single shared pipeline, which takes a new beat every cycle it moves.
//   The whole pipeline moves when rsp is empty or taken; while rsp is held
//   off every stage holds and req.ready is low, so nothing is lost or
//   repeated. Bubbles travel as invalid stages.
//   Synchronous active-high reset empties the pipeline; rsp.valid is low
//   in the cycle after reset.
`include "assert_macros.svh"

module triangle_face_normal_quantizer_top #(
   parameter int COORD_WIDTH = tfnq_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   tfnq_req_if.sink   req,
   tfnq_rsp_if.source rsp
);
   localparam int M  = 2 * COORD_WIDTH + 1;
   localparam int SQ = 2 * M;
   localparam int LW = SQ + 2;
   localparam int KW = SQ + tfnq_pkg::SCALE_SQ_HI;
   localparam int RW = LW + tfnq_pkg::Q_BITS;
   localparam int NQ = tfnq_pkg::Q_BITS;
   localparam int OW = tfnq_pkg::OUT_WIDTH;

   logic adv;

   tfnq_pkg::ctrl_type ctrl_cr, ctrl_sq;
   logic [2:0][M-1:0]  mag_cr;
   logic [2:0]         neg_cr;

   tfnq_pkg::ctrl_type                ctrl_q [0:NQ];
   logic [2:0]                        neg_q  [0:NQ];
   logic [LW-1:0]                     len_q  [0:NQ];
   logic [2:0][KW-1:0]                k_q    [0:NQ];
   logic [2:0][KW-1:0]                p_q    [0:NQ];
   logic [2:0][RW-1:0]                r_q    [0:NQ];
   logic [2:0][NQ-1:0]                q_q    [0:NQ];

   tfnq_pkg::ctrl_type    ctrl_out_ff;
   logic [2:0][OW-1:0]    norm_in, norm_ff;

   assign adv       = ~ctrl_out_ff.valid | rsp.ready;
   assign req.ready = adv;

   tfnq_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross (
      .clock  (clock),
      .reset  (reset),
      .adv    (adv),
      .ctrl_i ('{valid: req.valid, last: req.is_last, zero: 1'b0}),
      .p0_i   ({req.v0_z, req.v0_y, req.v0_x}),
      .p1_i   ({req.v1_z, req.v1_y, req.v1_x}),
      .p2_i   ({req.v2_z, req.v2_y, req.v2_x}),
      .ctrl_o (ctrl_cr),
      .mag_o  (mag_cr),
      .neg_o  (neg_cr)
   );

   tfnq_square #(.COORD_WIDTH(COORD_WIDTH)) u_square (
      .clock  (clock),
      .reset  (reset),
      .adv    (adv),
      .ctrl_i (ctrl_cr),
      .mag_i  (mag_cr),
      .neg_i  (neg_cr),
      .ctrl_o (ctrl_sq),
      .neg_o  (neg_q[0]),
      .len_o  (len_q[0]),
      .ksq_o  (k_q[0])
   );

   assign ctrl_q[0] = ctrl_sq;
   assign p_q[0]    = '0;
   assign r_q[0]    = '0;
   assign q_q[0]    = '0;

   // most significant bit of q first
   for (genvar g = 0; g < NQ; g++) begin : g_step
      tfnq_qstep #(.COORD_WIDTH(COORD_WIDTH), .BIT(NQ - 1 - g)) u_step (
         .clock  (clock),
         .reset  (reset),
         .adv    (adv),
         .ctrl_i (ctrl_q[g]),
         .neg_i  (neg_q[g]),
         .len_i  (len_q[g]),
         .ksq_i  (k_q[g]),
         .p_i    (p_q[g]),
         .r_i    (r_q[g]),
         .q_i    (q_q[g]),
         .ctrl_o (ctrl_q[g+1]),
         .neg_o  (neg_q[g+1]),
         .len_o  (len_q[g+1]),
         .ksq_o  (k_q[g+1]),
         .p_o    (p_q[g+1]),
         .r_o    (r_q[g+1]),
         .q_o    (q_q[g+1])
      );
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (ctrl_q[NQ].zero) begin
            norm_in[i] = '0;
         end else if (neg_q[NQ][i]) begin
            norm_in[i] = ~{1'b0, q_q[NQ][i]} + 1'b1;
         end else begin
            norm_in[i] = {1'b0, q_q[NQ][i]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_out_ff <= '0;
      end else if (adv) begin
         ctrl_out_ff <= ctrl_q[NQ];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         norm_ff <= norm_in;
      end
   end

   assign rsp.valid    = ctrl_out_ff.valid;
   assign rsp.last_out = ctrl_out_ff.last;
   assign rsp.normal_x = norm_ff[0];
   assign rsp.normal_y = norm_ff[1];
   assign rsp.normal_z = norm_ff[2];

   `ASSERT_ANY(a_reset_empties, reset |=> !rsp.valid, "pipeline not empty after reset")
   `ASSERT_CLK(a_stall_holds, !adv |=> $stable({ctrl_cr.valid, ctrl_sq.valid, ctrl_q[NQ].valid, ctrl_out_ff.valid}), "valid bits moved during stall")
   `ASSERT_CLK(a_search_consistent, ctrl_q[NQ].valid |-> ((q_q[NQ][0] != '0) || ((r_q[NQ][0] == '0) && (p_q[NQ][0] == '0))) && (p_q[NQ][0] <= k_q[NQ][0]), "search state inconsistent on x lane")
   `ASSERT_CLK(a_no_min_byte, rsp.valid |-> (rsp.normal_x != 8'h80) && (rsp.normal_y != 8'h80) && (rsp.normal_z != 8'h80), "normal component out of range")
endmodule

[tb/sv/tb.sv]
// Testbench for triangle_face_normal_quantizer_top: random and directed triangles,
// exact face-normal prediction with a scoreboard, random stalls on both channels.
// Depends on tfnq_pkg, tfnq_req_if, tfnq_rsp_if and the top-level RTL.
`timescale 1ns / 100ps

module tb;

   localparam int CW       = tfnq_pkg::COORD_WIDTH_DEFAULT;
   localparam int N_RANDOM = 1600;
   localparam int WD_LIMIT = 4000;

   typedef struct packed {
      logic [8:0][CW-1:0] c;      // v0 xyz, v1 xyz, v2 xyz
      logic               last;
   } triangle_type;

   typedef struct packed {
      logic [tfnq_pkg::OUT_WIDTH-1:0] nx;
      logic [tfnq_pkg::OUT_WIDTH-1:0] ny;
      logic [tfnq_pkg::OUT_WIDTH-1:0] nz;
      logic                           last;
   } normal_type;

   class normal_scoreboard;
      normal_type pending[$];
      int         errors;

      // largest q in 0..127 with q*q*len <= 127*127*c*c, signed like c
      function automatic logic [tfnq_pkg::OUT_WIDTH-1:0] quant(logic signed [63:0] c,
                                                               logic [127:0] len);
         logic [127:0] m, rhs, lhs, t;
         int q, b;
         m = (c < 0) ? 128'(-c) : 128'(c);
         rhs = m * m * 128'd16129;
         q = 0;
         for (b = 64; b > 0; b = b >> 1) begin
            t = 128'(q | b);
            lhs = len * (t * t);
            if (lhs <= rhs) q = q | b;
         end
         return (c < 0) ? tfnq_pkg::OUT_WIDTH'(-q) : tfnq_pkg::OUT_WIDTH'(q);
      endfunction

      function automatic normal_type face_normal(triangle_type t);
         logic signed [63:0] p[9];
         logic signed [63:0] ax, ay, az, bx, by, bz, nx, ny, nz;
         logic [127:0] mx, my, mz, len;
         normal_type r;
         // c[8] holds v0_x, c[0] holds v2_z
         for (int i = 0; i < 9; i++) p[i] = $signed(t.c[8-i]);
         ax = p[3] - p[0]; ay = p[4] - p[1]; az = p[5] - p[2];
         bx = p[6] - p[0]; by = p[7] - p[1]; bz = p[8] - p[2];
         nx = ay * bz - az * by;
         ny = az * bx - ax * bz;
         nz = ax * by - ay * bx;
         mx = (nx < 0) ? 128'(-nx) : 128'(nx);
         my = (ny < 0) ? 128'(-ny) : 128'(ny);
         mz = (nz < 0) ? 128'(-nz) : 128'(nz);
         len = mx * mx + my * my + mz * mz;
         if (len == 0) begin
            r.nx = '0; r.ny = '0; r.nz = '0;
         end else begin
            r.nx = quant(nx, len);
            r.ny = quant(ny, len);
            r.nz = quant(nz, len);
         end
         r.last = t.last;
         return r;
      endfunction

      function void note(triangle_type t);
         pending.push_back(face_normal(t));
      endfunction

      function void check(normal_type got);
         normal_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected beat %h", $time, got);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.nx !== e.nx) begin
            $display("%0t: normal_x exp %0d got %0d", $time, $signed(e.nx), $signed(got.nx));
            errors++;
         end
         if (got.ny !== e.ny) begin
            $display("%0t: normal_y exp %0d got %0d", $time, $signed(e.ny), $signed(got.ny));
            errors++;
         end
         if (got.nz !== e.nz) begin
            $display("%0t: normal_z exp %0d got %0d", $time, $signed(e.nz), $signed(got.nz));
            errors++;
         end
         if (got.last !== e.last) begin
            $display("%0t: last_out exp %b got %b", $time, e.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   bit   quiet = 0;          // no idling in the last part of the run
   int   idle_cycles = 0;
   normal_scoreboard sb = new();

   tfnq_req_if #(.COORD_WIDTH(CW)) req_if();
   tfnq_rsp_if                     rsp_if();

   triangle_face_normal_quantizer_top #(.COORD_WIDTH(CW)) u_dut (
      .clock(clock), .reset(reset), .req(req_if), .rsp(rsp_if)
   );

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   initial begin
      req_if.valid = 0;
      req_if.v0_x = '0; req_if.v0_y = '0; req_if.v0_z = '0;
      req_if.v1_x = '0; req_if.v1_y = '0; req_if.v1_z = '0;
      req_if.v2_x = '0; req_if.v2_y = '0; req_if.v2_z = '0;
      req_if.is_last = 0;
      rsp_if.ready = 0;
   end

   // result side: random stall bursts
   int rsp_hold = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 0;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_if.ready <= 0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         rsp_hold = $urandom_range(1, 7) - 1;
         rsp_if.ready <= 0;
      end else begin
         rsp_if.ready <= 1;
      end
   end

   // monitors and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready)
            sb.note({req_if.v0_x, req_if.v0_y, req_if.v0_z, req_if.v1_x, req_if.v1_y,
                     req_if.v1_z, req_if.v2_x, req_if.v2_y, req_if.v2_z, req_if.is_last});
         if (rsp_if.valid && rsp_if.ready)
            sb.check({rsp_if.normal_x, rsp_if.normal_y, rsp_if.normal_z, rsp_if.last_out});
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WD_LIMIT) begin
            $display("tb: done, errors");
            $finish;
         end
      end
   end

   int snd_hold = 0;

   task automatic send_triangle(triangle_type t);
      {req_if.v0_x, req_if.v0_y, req_if.v0_z, req_if.v1_x, req_if.v1_y,
       req_if.v1_z, req_if.v2_x, req_if.v2_y, req_if.v2_z} <= t.c;
      req_if.is_last <= t.last;
      req_if.valid <= 1;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
      // sender gap burst
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_if.valid <= 0;
         snd_hold = $urandom_range(1, 7);
         repeat (snd_hold) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_if.valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   function automatic logic [CW-1:0] rand_coord(int mode);
      case (mode)
         0: return CW'($urandom);
         1: return CW'($urandom_range(0, 4095)) - CW'(2048);
         2: return $urandom_range(0, 1) ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
         default: return CW'($urandom_range(0, 255)) - CW'(128);
      endcase
   endfunction

   function automatic triangle_type rand_triangle();
      triangle_type t;
      int mode, kind;
      mode = $urandom_range(0, 3);
      for (int i = 0; i < 9; i++) t.c[i] = rand_coord(mode);
      kind = $urandom_range(0, 9);
      if (kind == 0) t.c[5:3] = t.c[2:0];              // coincident vertices
      else if (kind == 1) begin                         // collinear: p0 - p2 = 2(p1 - p2)
         for (int i = 0; i < 3; i++)
            t.c[6+i] = t.c[i] + ((t.c[3+i] - t.c[i]) << 1);
      end else if (kind == 2) begin                     // flat in x
         t.c[5] = t.c[2]; t.c[8] = t.c[2];
      end
      t.last = 1'($urandom_range(0, 1));
      return t;
   endfunction

   function automatic triangle_type make_tri(int a0, a1, a2, b0, b1, b2, c0, c1, c2, bit l);
      triangle_type t;
      t.c = {CW'(a0), CW'(a1), CW'(a2), CW'(b0), CW'(b1), CW'(b2), CW'(c0), CW'(c1), CW'(c2)};
      t.last = l;
      return t;
   endfunction

   localparam int CMAX = (1 << (CW - 1)) - 1;
   localparam int CMIN = -(1 << (CW - 1));

   initial begin
      triangle_type t;
      repeat (3) @(posedge clock);
      reset <= 0;

      // directed corners
      send_triangle(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_triangle(make_tri(0, 0, 0, 256, 0, 0, 0, 256, 0, 1));          // +z
      send_triangle(make_tri(0, 0, 0, 0, 256, 0, 256, 0, 0, 0));          // -z
      send_triangle(make_tri(0, 0, 0, 0, 256, 0, 0, 0, 256, 1));          // +x
      send_triangle(make_tri(0, 0, 0, 0, 0, 256, 256, 0, 0, 0));          // +y
      send_triangle(make_tri(0, 0, 0, 1, 1, 1, 2, 2, 2, 1));              // collinear
      send_triangle(make_tri(5, 5, 5, 5, 5, 5, 9, 1, 3, 0));              // coincident
      send_triangle(make_tri(CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, 1));
      send_triangle(make_tri(CMAX, CMAX, CMAX, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, 0));
      send_triangle(make_tri(CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMAX, CMIN, 1));
      send_triangle(make_tri(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 1));
      send_triangle(make_tri(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 0));
      send_triangle(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 1, 0));              // 45 degrees
      send_triangle(make_tri(-1, -1, -1, 1, 2, 3, -3, 5, -7, 1));
      send_triangle(make_tri(0, 0, 0, CMAX, 0, 0, 0, 1, 0, 0));           // long/short edges
      send_triangle(make_tri(0, 0, 0, 3, 0, 0, 0, 4, 5, 1));

      // hold off until everything is back
      drain();

      for (int n = 0; n < N_RANDOM; n++) begin
         if (n == N_RANDOM - 200) quiet = 1;
         if (n == N_RANDOM / 2) drain();
         t = rand_triangle();
         send_triangle(t);
      end
      drain();
      repeat (40) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end
endmodule

[filelist.f]
+incdir+src
src/tfnq_pkg.sv
src/tfnq_req_if.sv
src/tfnq_rsp_if.sv
src/tfnq_cross.sv
src/tfnq_square.sv
src/tfnq_qstep.sv
src/triangle_face_normal_quantizer_top.sv
tb/sv/tb.sv
